>>> sv/psp_pkg.sv
package psp_pkg;

  localparam int STEP_N = 8;

  localparam int MAG_W = 28;
  localparam int COMP_W = MAG_W + 1;

  localparam logic [31:0] SAT_MAX = 32'h7fff_ffff;
  localparam logic [31:0] SAT_MIN = 32'h8000_0000;

  localparam logic [15:0] SIGN_HALF = 16'h8000;
  localparam logic [18:0] ORD_COUNT = 19'd6;

  localparam logic [2:0] ORD_C1C2C3 = 3'd0;
  localparam logic [2:0] ORD_C1C3C2 = 3'd1;
  localparam logic [2:0] ORD_C2C1C3 = 3'd2;
  localparam logic [2:0] ORD_C2C3C1 = 3'd3;
  localparam logic [2:0] ORD_C3C1C2 = 3'd4;
  localparam logic [2:0] ORD_C3C2C1 = 3'd5;

endpackage

>>> sv/pair_source_position_boost.sv
// throughput: one item per clock unless a held result stalls the pipeline; fully pipelined
// a stalled result freezes every stage; nothing is dropped or repeated
// synchronous reset clears the stage valid bits, result_valid and sigma
module pair_source_position_boost (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write_enable,
  input  logic        [15:0] cfg_write_data,
  input  logic               item_valid,
  output logic               item_stall,
  input  logic signed [31:0] total_px,
  input  logic signed [31:0] total_py,
  input  logic signed [31:0] total_pz,
  input  logic signed [31:0] total_energy,
  input  logic signed [15:0] gauss_draw,
  input  logic        [15:0] split_draw_a,
  input  logic        [15:0] split_draw_b,
  input  logic        [15:0] order_draw,
  input  logic        [15:0] sign_draw_a,
  input  logic        [15:0] sign_draw_b,
  input  logic        [15:0] sign_draw_c,
  output logic               result_valid,
  input  logic               result_stall,
  output logic signed [31:0] pos_x,
  output logic signed [31:0] pos_y,
  output logic signed [31:0] pos_z,
  output logic signed [31:0] pos_t,
  output logic               status
);
  import psp_pkg::*;

  function automatic logic [31:0] abs32(input logic signed [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

  function automatic logic signed [COMP_W-1:0] apply_sign(input logic [MAG_W-1:0] mag,
                                                          input logic flip);
    logic signed [COMP_W-1:0] v;
    v = $signed({1'b0, mag});
    return flip ? -v : v;
  endfunction

  logic        en;
  logic [32:1] vld;
  logic [15:0] sigma;

  // input stage and long delay lines
  logic signed [31:0] px_q [1:24];
  logic signed [31:0] py_q [1:24];
  logic signed [31:0] pz_q [1:24];
  logic signed [31:0] e1;
  logic signed [15:0] g1;
  logic        [15:0] fa_q [1:2];
  logic        [15:0] fb_q [1:9];
  logic        [15:0] sa_q [1:16];
  logic        [15:0] sb_q [1:16];
  logic        [15:0] sc_q [1:16];
  logic        [15:0] ord_q [1:16];

  // abs values and radius
  logic [31:0]      ax2, ay2, az2;
  logic [31:0]      ae_q [2:24];
  logic             se_q [2:25];
  logic             gneg_q [2:16];
  logic [MAG_W-1:0] mag_q [2:3];
  logic [15:0]      gabs;
  logic [31:0]      rprod;

  // squares and components
  logic [63:0]      axs, ays, azs, aes;
  logic [MAG_W-1:0] c1m_q [3:16];
  logic [43:0]      c1prod;
  logic [63:0]      pt2_4, mt2_4;
  logic [55:0]      rsq, c1sq;
  logic             deg_q [5:32];
  logic [63:0]      m2_5, mt2_5, pt2_5;
  logic [55:0]      d_q [5:11];

  logic [31:0]      m_r, mt_r, pt_r, rt_r, c3_r;
  logic [31:0]      m_q [10:18];
  logic [31:0]      mt_q [10:26];
  logic [31:0]      pt_q [10:26];
  logic [43:0]      c2prod;
  logic [MAG_W-1:0] c2_q [10:16];
  logic [55:0]      c2sq;
  logic [55:0]      d3;

  // ordering and boost
  logic signed [COMP_W-1:0] c1s, c2s, c3s, os_c, ss_c, ls_c;
  logic        [18:0]       ordx6;
  logic signed [COMP_W-1:0] os17;
  logic signed [COMP_W-1:0] ss_q [17:24];
  logic signed [COMP_W-1:0] ls_q [17:24];
  logic signed [63:0]       pom, pop;
  logic signed [31:0]       outv, dtl;
  logic signed [63:0]       aels, pzdtl, aedtl, pzls, opx, sspy, opy, sspx;
  logic signed [63:0]       zn, tn, xn, yn;
  logic signed [31:0]       zq, tq, xq, yq;

  assign en = !(result_valid && result_stall);
  assign item_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      result_valid <= 1'b0;
      sigma <= '0;
    end else begin
      if (cfg_write_enable) begin
        sigma <= cfg_write_data;
      end
      if (en) begin
        vld <= {vld[31:1], item_valid};
        result_valid <= vld[32];
      end
    end
  end

  always_comb begin
    gabs = g1[15] ? (~g1 + 16'd1) : g1;
    rprod = sigma * gabs;
    c1prod = fa_q[2] * mag_q[2];
    c2prod = fb_q[9] * rt_r[MAG_W-1:0];
    ordx6 = {3'b000, ord_q[16]} * ORD_COUNT;
    c1s = apply_sign(c1m_q[16], gneg_q[16] ^ (sa_q[16] > SIGN_HALF));
    c2s = apply_sign(c2_q[16], sb_q[16] > SIGN_HALF);
    c3s = apply_sign(c3_r[MAG_W-1:0], sc_q[16] > SIGN_HALF);
    case (ordx6[18:16])
      ORD_C1C2C3: begin
        os_c = c1s; ss_c = c2s; ls_c = c3s;
      end
      ORD_C1C3C2: begin
        os_c = c1s; ss_c = c3s; ls_c = c2s;
      end
      ORD_C2C1C3: begin
        os_c = c2s; ss_c = c1s; ls_c = c3s;
      end
      ORD_C2C3C1: begin
        os_c = c2s; ss_c = c3s; ls_c = c1s;
      end
      ORD_C3C1C2: begin
        os_c = c3s; ss_c = c1s; ls_c = c2s;
      end
      ORD_C3C2C1: begin
        os_c = c3s; ss_c = c2s; ls_c = c1s;
      end
      default: begin
        os_c = c3s; ss_c = c2s; ls_c = c1s;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // stage 1
      px_q[1] <= total_px;
      py_q[1] <= total_py;
      pz_q[1] <= total_pz;
      e1 <= total_energy;
      g1 <= gauss_draw;
      fa_q[1] <= split_draw_a;
      fb_q[1] <= split_draw_b;
      sa_q[1] <= sign_draw_a;
      sb_q[1] <= sign_draw_b;
      sc_q[1] <= sign_draw_c;
      ord_q[1] <= order_draw;
      for (int i = 2; i <= 24; i++) begin
        px_q[i] <= px_q[i-1];
        py_q[i] <= py_q[i-1];
        pz_q[i] <= pz_q[i-1];
      end
      fa_q[2] <= fa_q[1];
      for (int i = 2; i <= 9; i++) begin
        fb_q[i] <= fb_q[i-1];
      end
      for (int i = 2; i <= 16; i++) begin
        sa_q[i] <= sa_q[i-1];
        sb_q[i] <= sb_q[i-1];
        sc_q[i] <= sc_q[i-1];
        ord_q[i] <= ord_q[i-1];
      end

      // stage 2
      ax2 <= abs32(px_q[1]);
      ay2 <= abs32(py_q[1]);
      az2 <= abs32(pz_q[1]);
      ae_q[2] <= abs32(e1);
      se_q[2] <= e1[31];
      gneg_q[2] <= g1[15];
      mag_q[2] <= rprod[MAG_W+2:3];
      for (int i = 3; i <= 24; i++) begin
        ae_q[i] <= ae_q[i-1];
      end
      for (int i = 3; i <= 25; i++) begin
        se_q[i] <= se_q[i-1];
      end
      for (int i = 3; i <= 16; i++) begin
        gneg_q[i] <= gneg_q[i-1];
      end

      // stage 3
      axs <= ax2 * ax2;
      ays <= ay2 * ay2;
      azs <= az2 * az2;
      aes <= ae_q[2] * ae_q[2];
      mag_q[3] <= mag_q[2];
      c1m_q[3] <= c1prod[MAG_W+15:16];
      for (int i = 4; i <= 16; i++) begin
        c1m_q[i] <= c1m_q[i-1];
      end

      // stage 4
      pt2_4 <= axs + ays;
      mt2_4 <= aes - azs;
      rsq <= mag_q[3] * mag_q[3];
      c1sq <= c1m_q[3] * c1m_q[3];

      // stage 5
      deg_q[5] <= (pt2_4 == 64'd0) || mt2_4[63] || (mt2_4 == 64'd0) || (pt2_4 >= mt2_4);
      m2_5 <= mt2_4 - pt2_4;
      mt2_5 <= mt2_4;
      pt2_5 <= pt2_4;
      d_q[5] <= rsq - c1sq;
      for (int i = 6; i <= 32; i++) begin
        deg_q[i] <= deg_q[i-1];
      end
      for (int i = 6; i <= 11; i++) begin
        d_q[i] <= d_q[i-1];
      end

      // stage 10
      m_q[10] <= m_r;
      mt_q[10] <= mt_r;
      pt_q[10] <= pt_r;
      c2_q[10] <= c2prod[MAG_W+15:16];
      for (int i = 11; i <= 18; i++) begin
        m_q[i] <= m_q[i-1];
      end
      for (int i = 11; i <= 26; i++) begin
        mt_q[i] <= mt_q[i-1];
        pt_q[i] <= pt_q[i-1];
      end
      for (int i = 11; i <= 16; i++) begin
        c2_q[i] <= c2_q[i-1];
      end

      // stages 11 and 12
      c2sq <= c2_q[10] * c2_q[10];
      d3 <= d_q[11] - c2sq;

      // stage 17
      os17 <= os_c;
      ss_q[17] <= ss_c;
      ls_q[17] <= ls_c;
      for (int i = 18; i <= 24; i++) begin
        ss_q[i] <= ss_q[i-1];
        ls_q[i] <= ls_q[i-1];
      end

      // stage 18
      pom <= os17 * $signed({1'b0, mt_q[17]});
      pop <= os17 * $signed({1'b0, pt_q[17]});

      // stage 25
      aels <= $signed({1'b0, ae_q[24]}) * ls_q[24];
      pzdtl <= pz_q[24] * dtl;
      aedtl <= $signed({1'b0, ae_q[24]}) * dtl;
      pzls <= pz_q[24] * ls_q[24];
      opx <= outv * px_q[24];
      sspy <= ss_q[24] * py_q[24];
      opy <= outv * py_q[24];
      sspx <= ss_q[24] * px_q[24];

      // stage 26
      zn <= aels + (se_q[25] ? -pzdtl : pzdtl);
      tn <= aedtl + (se_q[25] ? -pzls : pzls);
      xn <= opx - sspy;
      yn <= opy + sspx;

      // stage 33
      pos_x <= deg_q[32] ? 32'sd0 : xq;
      pos_y <= deg_q[32] ? 32'sd0 : yq;
      pos_z <= deg_q[32] ? 32'sd0 : zq;
      pos_t <= deg_q[32] ? 32'sd0 : tq;
      status <= deg_q[32];
    end
  end

  psp_isqrt u_sqrt_m  (.clk(clk), .en(en), .x(m2_5),            .root(m_r));
  psp_isqrt u_sqrt_mt (.clk(clk), .en(en), .x(mt2_5),           .root(mt_r));
  psp_isqrt u_sqrt_pt (.clk(clk), .en(en), .x(pt2_5),           .root(pt_r));
  psp_isqrt u_sqrt_rt (.clk(clk), .en(en), .x({8'b0, d_q[5]}),  .root(rt_r));
  psp_isqrt u_sqrt_c3 (.clk(clk), .en(en), .x({8'b0, d3}),      .root(c3_r));

  psp_div u_div_out (.clk(clk), .en(en), .num(pom), .den(m_q[18]),  .quo(outv));
  psp_div u_div_dtl (.clk(clk), .en(en), .num(pop), .den(m_q[18]),  .quo(dtl));
  psp_div u_div_z   (.clk(clk), .en(en), .num(zn),  .den(mt_q[26]), .quo(zq));
  psp_div u_div_t   (.clk(clk), .en(en), .num(tn),  .den(mt_q[26]), .quo(tq));
  psp_div u_div_x   (.clk(clk), .en(en), .num(xn),  .den(pt_q[26]), .quo(xq));
  psp_div u_div_y   (.clk(clk), .en(en), .num(yn),  .den(pt_q[26]), .quo(yq));

endmodule

>>> sv/psp_isqrt.sv
module psp_isqrt (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] x,
  output logic [31:0] root
);
  import psp_pkg::*;

  localparam int STAGES = 32 / STEP_N;

  typedef struct packed {
    logic [63:0] x;
    logic [33:0] rem;
    logic [31:0] root;
  } sqrt_st_t;

  function automatic sqrt_st_t sqrt_steps(input sqrt_st_t s);
    sqrt_st_t    r;
    logic [33:0] a;
    logic [33:0] t;
    r = s;
    for (int i = 0; i < STEP_N; i++) begin
      a = {r.rem[31:0], r.x[63:62]};
      t = {r.root, 2'b01};
      r.x = {r.x[61:0], 2'b00};
      if (a >= t) begin
        r.rem = a - t;
        r.root = {r.root[30:0], 1'b1};
      end else begin
        r.rem = a;
        r.root = {r.root[30:0], 1'b0};
      end
    end
    return r;
  endfunction

  sqrt_st_t st [STAGES];
  sqrt_st_t nx [STAGES];
  sqrt_st_t st_in;

  always_comb begin
    st_in.x = x;
    st_in.rem = '0;
    st_in.root = '0;
    nx[0] = sqrt_steps(st_in);
    for (int i = 1; i < STAGES; i++) begin
      nx[i] = sqrt_steps(st[i-1]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < STAGES; i++) begin
        st[i] <= nx[i];
      end
    end
  end

  assign root = st[STAGES-1].root;

endmodule

>>> sv/psp_div.sv
module psp_div (
  input  logic               clk,
  input  logic               en,
  input  logic signed [63:0] num,
  input  logic        [31:0] den,
  output logic signed [31:0] quo
);
  import psp_pkg::*;

  localparam int STAGES = 32 / STEP_N;

  typedef struct packed {
    logic [31:0] rem;
    logic [31:0] lo;
    logic [31:0] q;
    logic [31:0] den;
    logic        neg;
    logic        ovf;
  } div_st_t;

  function automatic div_st_t div_steps(input div_st_t s);
    div_st_t     r;
    logic [32:0] a;
    r = s;
    for (int i = 0; i < STEP_N; i++) begin
      a = {r.rem, r.lo[31]};
      r.lo = {r.lo[30:0], 1'b0};
      if (a >= {1'b0, r.den}) begin
        r.rem = 32'(a - {1'b0, r.den});
        r.q = {r.q[30:0], 1'b1};
      end else begin
        r.rem = a[31:0];
        r.q = {r.q[30:0], 1'b0};
      end
    end
    return r;
  endfunction

  logic [63:0] an;
  div_st_t     st_in;
  div_st_t     st [STAGES+1];
  div_st_t     last;
  logic [31:0] quo_next;

  always_comb begin
    an = num[63] ? (~num + 64'd1) : num;
    st_in.rem = an[63:32];
    st_in.lo = an[31:0];
    st_in.q = '0;
    st_in.den = den;
    st_in.neg = num[63];
    st_in.ovf = (an[63:32] >= den);
  end

  always_comb begin
    last = st[STAGES];
    if (last.ovf) begin
      quo_next = last.neg ? SAT_MIN : SAT_MAX;
    end else if (!last.neg) begin
      quo_next = last.q[31] ? SAT_MAX : last.q;
    end else begin
      quo_next = (last.q > SAT_MIN) ? SAT_MIN : (~last.q + 32'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st[0] <= st_in;
      for (int i = 1; i <= STAGES; i++) begin
        st[i] <= div_steps(st[i-1]);
      end
      quo <= $signed(quo_next);
    end
  end

endmodule

>>> sv/psp_checker.sv
module psp_checker (
  input logic               clk,
  input logic               rst,
  input logic               item_stall,
  input logic               result_valid,
  input logic               result_stall,
  input logic signed [31:0] pos_x,
  input logic signed [31:0] pos_y,
  input logic signed [31:0] pos_z,
  input logic signed [31:0] pos_t,
  input logic               status
);

  // degenerate momentum gives a zero point
  assert property (@(posedge clk) disable iff (rst)
    result_valid && status |-> pos_x == 0 && pos_y == 0 && pos_z == 0 && pos_t == 0)
    else $error("degenerate item with nonzero position");

  assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid right after reset");

  // input side only backs up behind a held result
  assert property (@(posedge clk) disable iff (rst)
    item_stall |-> result_valid && result_stall)
    else $error("input stalled without a held result");

  assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(pos_x) && $stable(pos_t)
      && $stable(status))
    else $error("held result changed");

endmodule

bind pair_source_position_boost psp_checker u_psp_checker (.*);
